// ===== design/b64jsd_pkg.sv =====
// Package for the base64 text decoder: codes, types and character tables.
package b64jsd_pkg;

  localparam int CountWidth = 16;
  localparam int QueueDepth = 4;
  localparam int QueuePtrW  = $clog2(QueueDepth);
  localparam int MaxResults = 3;

  localparam logic [7:0] CharDquote = 8'h22;
  localparam logic [7:0] CharSquote = 8'h27;
  localparam logic [7:0] CharBslash = 8'h5c;
  localparam logic [6:0] PadCode    = 7'd64;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_DATA    = 2'd0,
    KIND_DONE    = 2'd1,
    KIND_INVALID = 2'd2,
    KIND_NOROOM  = 2'd3
  } kind_t;

  // Text phase
  typedef enum logic [2:0] {
    PH_IDLE  = 3'b001,
    PH_TEXT  = 3'b010,
    PH_DRAIN = 3'b100
  } phase_t;

  // Escape sequence progress
  typedef enum logic [5:0] {
    ESC_NONE = 6'b000001,
    ESC_BSL  = 6'b000010,
    ESC_U0   = 6'b000100,
    ESC_U1   = 6'b001000,
    ESC_HEX0 = 6'b010000,
    ESC_HEX1 = 6'b100000
  } esc_t;

  // Character classes
  typedef enum logic [1:0] {
    SYM_DIGIT = 2'd0,
    SYM_PAD   = 2'd1,
    SYM_SPC   = 2'd2,
    SYM_BAD   = 2'd3
  } sym_cls_t;

  typedef struct packed {
    sym_cls_t   cls;
    logic [5:0] val;
  } sym_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  typedef struct packed {
    kind_t                 kind;
    logic [7:0]            data;
    logic [CountWidth-1:0] count;
    logic                  last;
  } res_t;

  // Base64 alphabet lookup
  function automatic sym_t digit_of(input logic [7:0] c);
    sym_t s;
    s.cls = SYM_DIGIT;
    s.val = 6'd0;
    if (c >= 8'h41 && c <= 8'h5a) begin
      s.val = 6'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7a) begin
      s.val = 6'(c - 8'h61 + 8'd26);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      s.val = 6'(c - 8'h30 + 8'd52);
    end else if (c == 8'h2b) begin
      s.val = 6'd62;
    end else if (c == 8'h2f) begin
      s.val = 6'd63;
    end else if (c == 8'h3d) begin
      s.cls = SYM_PAD;
    end else if (c == 8'h09 || c == 8'h0a || c == 8'h0c || c == 8'h0d || c == 8'h20) begin
      s.cls = SYM_SPC;
    end else begin
      s.cls = SYM_BAD;
    end
    return s;
  endfunction

  // Hex digit lookup
  function automatic hex_t hex_of(input logic [7:0] c);
    hex_t h;
    h.ok  = 1'b1;
    h.val = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.val = 4'(c - 8'h30);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      h.val = 4'(c - 8'h41 + 8'd10);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      h.val = 4'(c - 8'h61 + 8'd10);
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

endpackage

// ===== design/base64_json_string_decoder.sv =====
// Top level of the base64 text decoder: character parser, group decoder and result queue.
//
// Takes one character of a quoted base64 text per transaction and returns the decoded
// bytes, then one status transaction (done, invalid or no room) carrying the byte count.
// Each accepted character is decoded in the cycle of acceptance and its results (none, a
// status, or up to three when it closes a group of four symbols) land in a four-entry
// result queue, which registers them before they reach the output. in_ready is high while
// at most one result is waiting in the queue, so the decoder takes one character every
// cycle while each character yields at most one result and the consumer takes results
// as they come; a character that yields two or three results holds the input while the
// queue drains them. A capacity of zero checks the text without emitting any byte. After
// a status the block drops characters up to the end-of-text mark (character 0), then waits
// for the next quote.
module base64_json_string_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [15:0] capacity,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  text_char,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  kind,
  output logic [7:0]  data_byte,
  output logic [15:0] byte_count,
  output logic        last
);

  localparam int CW = b64jsd_pkg::CountWidth;
  localparam int PW = b64jsd_pkg::QueuePtrW;

  // Decoder state
  logic [CW-1:0]        cap_reg;
  b64jsd_pkg::phase_t   phase, phase_next;
  logic                 quote_is_single, quote_is_single_next;
  b64jsd_pkg::esc_t     escape_step, escape_step_next;
  logic [3:0]           hex_acc, hex_acc_next;
  logic [1:0]           group_pos, group_pos_next;
  logic [6:0]           held_digits [3];
  logic [6:0]           held_digits_next [3];
  logic                 padding_seen, padding_seen_next;
  logic [CW-1:0]        stored_count, stored_count_next;

  // Result queue
  b64jsd_pkg::res_t     queue [b64jsd_pkg::QueueDepth];
  logic [PW-1:0]        rd_ptr, wr_ptr;
  logic [PW:0]          q_count;

  // Step outputs
  b64jsd_pkg::res_t     res [b64jsd_pkg::MaxResults];
  logic [1:0]           push_n;
  logic                 status_out;

  logic accept, pop;

  assign accept = in_valid && in_ready;
  assign pop    = out_valid && out_ready;

  // Per-character decode step
  always_comb begin
    b64jsd_pkg::sym_t  sd;
    b64jsd_pkg::hex_t  hx;
    logic              take;
    logic [7:0]        sym_in;
    logic [6:0]        dv;
    logic              status_req;
    b64jsd_pkg::kind_t status_kind;
    logic [1:0]        nb;
    logic [7:0]        bytes [3];
    logic              pad_set;
    logic              stop;
    logic [CW-1:0]     cnt;

    phase_next           = phase;
    quote_is_single_next = quote_is_single;
    escape_step_next     = escape_step;
    hex_acc_next         = hex_acc;
    group_pos_next       = group_pos;
    held_digits_next     = held_digits;
    padding_seen_next    = padding_seen;
    take        = 1'b0;
    sym_in      = text_char;
    status_req  = 1'b0;
    status_kind = b64jsd_pkg::KIND_INVALID;
    nb          = 2'd0;
    bytes[0]    = 8'd0;
    bytes[1]    = 8'd0;
    bytes[2]    = 8'd0;
    pad_set     = 1'b0;
    stop        = 1'b0;
    cnt         = stored_count;
    dv          = 7'd0;
    hx          = b64jsd_pkg::hex_of(text_char);
    for (int i = 0; i < b64jsd_pkg::MaxResults; i++) begin
      res[i] = '0;
    end
    push_n = 2'd0;

    // Phase and escape handling
    case (phase)
      b64jsd_pkg::PH_DRAIN: begin
        if (text_char == 8'd0) begin
          phase_next = b64jsd_pkg::PH_IDLE;
        end
      end
      b64jsd_pkg::PH_TEXT: begin
        case (escape_step)
          b64jsd_pkg::ESC_NONE: begin
            if (group_pos == 2'd0 && text_char ==
                (quote_is_single ? b64jsd_pkg::CharSquote : b64jsd_pkg::CharDquote)) begin
              status_req  = 1'b1;
              status_kind = b64jsd_pkg::KIND_DONE;
            end else if (text_char == b64jsd_pkg::CharBslash) begin
              escape_step_next = b64jsd_pkg::ESC_BSL;
            end else begin
              take = 1'b1;
            end
          end
          b64jsd_pkg::ESC_BSL: begin
            escape_step_next = b64jsd_pkg::ESC_NONE;
            if (text_char == 8'h6e) begin
              take   = 1'b1;
              sym_in = 8'h0a;
            end else if (text_char == 8'h74) begin
              take   = 1'b1;
              sym_in = 8'h09;
            end else if (text_char == 8'h66) begin
              take   = 1'b1;
              sym_in = 8'h0c;
            end else if (text_char == 8'h2f) begin
              take   = 1'b1;
            end else if (text_char == 8'h75) begin
              escape_step_next = b64jsd_pkg::ESC_U0;
            end else begin
              status_req = 1'b1;
            end
          end
          b64jsd_pkg::ESC_U0, b64jsd_pkg::ESC_U1: begin
            if (text_char != 8'h30) begin
              status_req = 1'b1;
            end else if (escape_step == b64jsd_pkg::ESC_U0) begin
              escape_step_next = b64jsd_pkg::ESC_U1;
            end else begin
              escape_step_next = b64jsd_pkg::ESC_HEX0;
            end
          end
          b64jsd_pkg::ESC_HEX0: begin
            if (!hx.ok) begin
              status_req = 1'b1;
            end else begin
              hex_acc_next     = hx.val;
              escape_step_next = b64jsd_pkg::ESC_HEX1;
            end
          end
          default: begin
            if (!hx.ok) begin
              status_req = 1'b1;
            end else begin
              escape_step_next = b64jsd_pkg::ESC_NONE;
              take             = 1'b1;
              sym_in           = {hex_acc, hx.val};
            end
          end
        endcase
      end
      default: begin
        // Waiting for the opening quote
        if (!(text_char == 8'h20 || text_char == 8'h09 || text_char == 8'h0a ||
              text_char == 8'h0d)) begin
          cnt = '0;
          if (text_char == b64jsd_pkg::CharDquote || text_char == b64jsd_pkg::CharSquote) begin
            quote_is_single_next = (text_char == b64jsd_pkg::CharSquote);
            phase_next           = b64jsd_pkg::PH_TEXT;
            escape_step_next     = b64jsd_pkg::ESC_NONE;
            hex_acc_next         = 4'd0;
            group_pos_next       = 2'd0;
            padding_seen_next    = 1'b0;
          end else begin
            status_req = 1'b1;
          end
        end
      end
    endcase

    // Symbol into the group of four
    sd = b64jsd_pkg::digit_of(sym_in);
    if (take && sd.cls != b64jsd_pkg::SYM_SPC) begin
      if (padding_seen || sd.cls == b64jsd_pkg::SYM_BAD) begin
        status_req = 1'b1;
      end else begin
        dv = (sd.cls == b64jsd_pkg::SYM_PAD) ? b64jsd_pkg::PadCode : {1'b0, sd.val};
        if (group_pos != 2'd3) begin
          held_digits_next[group_pos] = dv;
          group_pos_next              = group_pos + 2'd1;
        end else begin
          group_pos_next = 2'd0;
          if (held_digits[0] == b64jsd_pkg::PadCode ||
              held_digits[1] == b64jsd_pkg::PadCode) begin
            status_req = 1'b1;
          end else begin
            nb       = 2'd1;
            bytes[0] = {held_digits[0][5:0], held_digits[1][5:4]};
            bytes[1] = {held_digits[1][3:0], held_digits[2][5:2]};
            bytes[2] = {held_digits[2][1:0], dv[5:0]};
            if (held_digits[2] == b64jsd_pkg::PadCode) begin
              if (sd.cls != b64jsd_pkg::SYM_PAD) begin
                status_req = 1'b1;
              end else begin
                pad_set = 1'b1;
              end
            end else if (sd.cls == b64jsd_pkg::SYM_PAD) begin
              nb      = 2'd2;
              pad_set = 1'b1;
            end else begin
              nb = 2'd3;
            end
          end
        end
      end
    end

    // Byte emission against capacity
    for (int i = 0; i < b64jsd_pkg::MaxResults; i++) begin
      if (2'(i) < nb && !stop && cap_reg != '0) begin
        if (cnt < cap_reg) begin
          cnt               = cnt + CW'(1);
          res[push_n].kind  = b64jsd_pkg::KIND_DATA;
          res[push_n].data  = bytes[i];
          res[push_n].count = cnt;
          res[push_n].last  = 1'b0;
          push_n            = push_n + 2'd1;
        end else begin
          res[push_n].kind  = b64jsd_pkg::KIND_NOROOM;
          res[push_n].count = cnt;
          res[push_n].last  = 1'b1;
          push_n            = push_n + 2'd1;
          stop              = 1'b1;
        end
      end
    end
    if (status_req && !stop) begin
      res[push_n].kind  = status_kind;
      res[push_n].count = cnt;
      res[push_n].last  = 1'b1;
      push_n            = push_n + 2'd1;
    end
    if (pad_set && !stop) begin
      padding_seen_next = 1'b1;
    end

    // A status closes the text
    status_out = stop || status_req;
    if (status_out) begin
      phase_next       = (text_char == 8'd0) ? b64jsd_pkg::PH_IDLE : b64jsd_pkg::PH_DRAIN;
      escape_step_next = b64jsd_pkg::ESC_NONE;
      group_pos_next   = 2'd0;
    end
    stored_count_next = cnt;
  end

  // Capacity register
  always_ff @(posedge clk) begin
    if (rst) begin
      cap_reg <= '0;
    end else if (cfg_write) begin
      cap_reg <= capacity;
    end
  end

  // Decoder state update
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= b64jsd_pkg::PH_IDLE;
      quote_is_single <= 1'b0;
      escape_step     <= b64jsd_pkg::ESC_NONE;
      hex_acc         <= 4'd0;
      group_pos       <= 2'd0;
      held_digits[0]  <= 7'd0;
      held_digits[1]  <= 7'd0;
      held_digits[2]  <= 7'd0;
      padding_seen    <= 1'b0;
      stored_count    <= '0;
    end else if (accept) begin
      phase           <= phase_next;
      quote_is_single <= quote_is_single_next;
      escape_step     <= escape_step_next;
      hex_acc         <= hex_acc_next;
      group_pos       <= group_pos_next;
      held_digits     <= held_digits_next;
      padding_seen    <= padding_seen_next;
      stored_count    <= stored_count_next;
    end
  end

  // Result queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr  <= '0;
      wr_ptr  <= '0;
      q_count <= '0;
    end else begin
      if (pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      if (accept) begin
        wr_ptr <= wr_ptr + PW'(push_n);
      end
      q_count <= q_count + (accept ? (PW+1)'(push_n) : '0) - (PW+1)'(pop);
    end
  end

  // Result queue storage
  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < b64jsd_pkg::MaxResults; i++) begin
        if (2'(i) < push_n) begin
          queue[wr_ptr + PW'(i)] <= res[i];
        end
      end
    end
  end

  // Channel outputs
  assign in_ready   = (q_count <= (PW+1)'(b64jsd_pkg::QueueDepth - b64jsd_pkg::MaxResults));
  assign out_valid  = (q_count != '0);
  assign kind       = queue[rd_ptr].kind;
  assign data_byte  = queue[rd_ptr].data;
  assign byte_count = queue[rd_ptr].count;
  assign last       = queue[rd_ptr].last;

`ifndef SYNTHESIS
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_count <= (PW+1)'(b64jsd_pkg::QueueDepth))
    else $error("result queue overflow");

  a_drain_silent: assert property (@(posedge clk) disable iff (rst)
    (accept && phase == b64jsd_pkg::PH_DRAIN) |-> (push_n == 2'd0))
    else $error("results produced while draining");

  a_status_closes: assert property (@(posedge clk) disable iff (rst)
    (accept && status_out) |=> (phase != b64jsd_pkg::PH_TEXT))
    else $error("text still open after a status");

  a_escape_in_text: assert property (@(posedge clk) disable iff (rst)
    (escape_step != b64jsd_pkg::ESC_NONE) |-> (phase == b64jsd_pkg::PH_TEXT))
    else $error("escape pending outside a text");
`endif

endmodule

// ===== verif/base64_json_string_decoder_tb.sv =====
// Testbench for the base64 text decoder: directed and random texts checked by a predictor.
module base64_json_string_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT   = 500_000;
  localparam int SETTLE_CYCLES = 4;
  localparam int RANDOM_CHARS  = 90;

  // Character codes
  localparam logic [7:0] END_MARK = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_FF    = 8'h0c;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_EQ    = 8'h3d;
  localparam logic [7:0] CH_DQ    = b64jsd_pkg::CharDquote;
  localparam logic [7:0] CH_SQ    = b64jsd_pkg::CharSquote;
  localparam logic [7:0] CH_BSL   = b64jsd_pkg::CharBslash;
  localparam logic [6:0] PAD_CODE = b64jsd_pkg::PadCode;

  // Symbol classes returned by sextet_of besides the 0..63 digit values
  localparam logic [7:0] SPACE_SYM = 8'hfd;
  localparam logic [7:0] PAD_SYM   = 8'hfe;
  localparam logic [7:0] BAD_SYM   = 8'hff;

  logic        clk;
  logic        rst;
  logic        cfg_write;
  logic [15:0] capacity;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  text_char;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  kind;
  logic [7:0]  data_byte;
  logic [15:0] byte_count;
  logic        last;

  base64_json_string_decoder dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .capacity   (capacity),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .text_char  (text_char),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .kind       (kind),
    .data_byte  (data_byte),
    .byte_count (byte_count),
    .last       (last)
  );

  // Decoder state as predicted
  logic [15:0]        cap_reg;
  b64jsd_pkg::phase_t txt_phase;
  logic               single_q;
  b64jsd_pkg::esc_t   esc_state;
  logic [3:0]         hex_hi;
  logic [1:0]         grp_pos;
  logic [6:0]         held [3];
  logic               pad_seen;
  logic [15:0]        stored_bytes;
  b64jsd_pkg::res_t   awaited_results [$];

  // Run statistics and control shared with the receiver
  int mismatches = 0;
  int results_checked = 0;
  int chars_sent = 0;
  int chars_decoded = 0;
  int texts_sent = 0;
  int cap_writes = 0;
  int input_stall_cycles = 0;
  int cycle_count = 0;
  bit tx_gaps = 1'b1;
  bit rx_stalls = 1'b1;
  int rx_hold_req = 0;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic [7:0] sextet_of(input logic [7:0] c);
    if (c >= "A" && c <= "Z") return c - "A";
    if (c >= "a" && c <= "z") return c - "a" + 8'd26;
    if (c >= "0" && c <= "9") return c - "0" + 8'd52;
    if (c == CH_PLUS) return 8'd62;
    if (c == CH_SLASH) return 8'd63;
    if (c == CH_EQ) return PAD_SYM;
    if (c == CH_TAB || c == CH_LF || c == CH_FF || c == CH_CR || c == CH_SPACE)
      return SPACE_SYM;
    return BAD_SYM;
  endfunction

  // Bit 4 flags a valid hex digit
  function automatic logic [4:0] hex_nibble(input logic [7:0] c);
    if (c >= "0" && c <= "9") return {1'b1, 4'(c - "0")};
    if (c >= "A" && c <= "F") return {1'b1, 4'(c - "A" + 8'd10)};
    if (c >= "a" && c <= "f") return {1'b1, 4'(c - "a" + 8'd10)};
    return 5'd0;
  endfunction

  function automatic void predictor_reset();
    cap_reg      = '0;
    txt_phase    = b64jsd_pkg::PH_IDLE;
    single_q     = 1'b0;
    esc_state    = b64jsd_pkg::ESC_NONE;
    hex_hi       = '0;
    grp_pos      = '0;
    held[0]      = '0;
    held[1]      = '0;
    held[2]      = '0;
    pad_seen     = 1'b0;
    stored_bytes = '0;
  endfunction

  function automatic void push_result(input b64jsd_pkg::kind_t k, input logic [7:0] d);
    b64jsd_pkg::res_t r;
    r.kind  = k;
    r.data  = d;
    r.count = stored_bytes;
    r.last  = (k != b64jsd_pkg::KIND_DATA);
    awaited_results.push_back(r);
  endfunction

  // Status ends the text; a nonzero ending character means drain to the end mark
  function automatic void close_text(input b64jsd_pkg::kind_t k, input logic [7:0] raw);
    push_result(k, 8'h00);
    txt_phase = (raw == END_MARK) ? b64jsd_pkg::PH_IDLE : b64jsd_pkg::PH_DRAIN;
    esc_state = b64jsd_pkg::ESC_NONE;
    grp_pos   = '0;
  endfunction

  // Returns 0 once the no-room status has been given
  function automatic bit store_byte(input logic [7:0] b, input logic [7:0] raw);
    if (cap_reg == 16'd0) return 1'b1;
    if (stored_bytes >= cap_reg) begin
      close_text(b64jsd_pkg::KIND_NOROOM, raw);
      return 1'b0;
    end
    stored_bytes = stored_bytes + 16'd1;
    push_result(b64jsd_pkg::KIND_DATA, b);
    return 1'b1;
  endfunction

  function automatic void feed_symbol(input logic [7:0] sym, input logic [7:0] raw);
    logic [7:0] s;
    logic [6:0] d, v0, v1, v2;
    s = sextet_of(sym);
    if (s == SPACE_SYM) return;
    if (pad_seen || s == BAD_SYM) begin
      close_text(b64jsd_pkg::KIND_INVALID, raw);
      return;
    end
    d = (s == PAD_SYM) ? PAD_CODE : s[6:0];
    if (grp_pos != 2'd3) begin
      held[grp_pos] = d;
      grp_pos = grp_pos + 2'd1;
      return;
    end
    // Fourth symbol closes the group
    grp_pos = 2'd0;
    v0 = held[0];
    v1 = held[1];
    v2 = held[2];
    if (v0 == PAD_CODE || v1 == PAD_CODE) begin
      close_text(b64jsd_pkg::KIND_INVALID, raw);
      return;
    end
    if (!store_byte({v0[5:0], v1[5:4]}, raw)) return;
    if (v2 == PAD_CODE) begin
      if (d != PAD_CODE) close_text(b64jsd_pkg::KIND_INVALID, raw);
      else pad_seen = 1'b1;
    end else begin
      if (!store_byte({v1[3:0], v2[5:2]}, raw)) return;
      if (d == PAD_CODE) pad_seen = 1'b1;
      else void'(store_byte({v2[1:0], d[5:0]}, raw));
    end
  endfunction

  function automatic void decode_char(input logic [7:0] c);
    logic [4:0] h;
    if (txt_phase == b64jsd_pkg::PH_DRAIN) begin
      if (c == END_MARK) txt_phase = b64jsd_pkg::PH_IDLE;
      return;
    end
    // Waiting for the opening quote
    if (txt_phase != b64jsd_pkg::PH_TEXT) begin
      if (c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR) return;
      stored_bytes = '0;
      if (c == CH_DQ || c == CH_SQ) begin
        single_q  = (c == CH_SQ);
        txt_phase = b64jsd_pkg::PH_TEXT;
        esc_state = b64jsd_pkg::ESC_NONE;
        hex_hi    = '0;
        grp_pos   = '0;
        pad_seen  = 1'b0;
      end else begin
        close_text(b64jsd_pkg::KIND_INVALID, c);
      end
      return;
    end
    h = hex_nibble(c);
    case (esc_state)
      b64jsd_pkg::ESC_NONE: begin
        if (grp_pos == 2'd0 && c == (single_q ? CH_SQ : CH_DQ))
          close_text(b64jsd_pkg::KIND_DONE, c);
        else if (c == CH_BSL)
          esc_state = b64jsd_pkg::ESC_BSL;
        else
          feed_symbol(c, c);
      end
      b64jsd_pkg::ESC_BSL: begin
        esc_state = b64jsd_pkg::ESC_NONE;
        case (c)
          "n":      feed_symbol(CH_LF, c);
          "t":      feed_symbol(CH_TAB, c);
          "f":      feed_symbol(CH_FF, c);
          CH_SLASH: feed_symbol(CH_SLASH, c);
          "u":      esc_state = b64jsd_pkg::ESC_U0;
          default:  close_text(b64jsd_pkg::KIND_INVALID, c);
        endcase
      end
      b64jsd_pkg::ESC_U0, b64jsd_pkg::ESC_U1: begin
        if (c != "0") close_text(b64jsd_pkg::KIND_INVALID, c);
        else esc_state = (esc_state == b64jsd_pkg::ESC_U0) ? b64jsd_pkg::ESC_U1
                                                           : b64jsd_pkg::ESC_HEX0;
      end
      b64jsd_pkg::ESC_HEX0: begin
        if (!h[4]) begin
          close_text(b64jsd_pkg::KIND_INVALID, c);
        end else begin
          hex_hi = h[3:0];
          esc_state = b64jsd_pkg::ESC_HEX1;
        end
      end
      default: begin
        if (!h[4]) begin
          close_text(b64jsd_pkg::KIND_INVALID, c);
        end else begin
          esc_state = b64jsd_pkg::ESC_NONE;
          feed_symbol({hex_hi, h[3:0]}, c);
        end
      end
    endcase
  endfunction

  // ---------------------------------------------------------------- helpers

  // Mostly back to back, some short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [7:0] pick_blank(input bit leading);
    case ($urandom_range(0, leading ? 3 : 4))
      0:       return CH_SPACE;
      1:       return CH_TAB;
      2:       return CH_LF;
      3:       return CH_CR;
      default: return CH_FF;
    endcase
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n, input bit upper);
    if (n < 4'd10) return "0" + n;
    return (upper ? "A" : "a") + n - 8'd10;
  endfunction

  // One character transaction, with an optional gap in front
  task automatic send_char(input logic [7:0] c);
    int gap;
    gap = tx_gaps ? pick_gap() : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid  <= 1'b1;
    text_char <= c;
    @(posedge clk);
    while (!in_ready) begin
      input_stall_cycles++;
      @(posedge clk);
    end
    if (txt_phase != b64jsd_pkg::PH_DRAIN) chars_decoded++;
    if (c == END_MARK) texts_sent++;
    chars_sent++;
    decode_char(c);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  task automatic send_text_end(input string s);
    send_text(s);
    send_char(END_MARK);
  endtask

  // Input quiet, every awaited result in, then a short settle
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [15:0] v);
    wait_idle();
    @(negedge clk);
    cfg_write <= 1'b1;
    capacity  <= v;
    cap_reg = v;
    @(negedge clk);
    cfg_write <= 1'b0;
    cap_writes++;
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_plain_groups();
    write_capacity(16'd100);
    send_text_end("  \"TWFu\"");
    send_text_end("'TWE='");
    send_text_end("\"TQ==\"");
    send_text_end("\"+/AZaz09\"");
    send_text_end("\"\"");
  endtask

  task automatic test_framing();
    // leading blanks, then a blank inside a group
    send_char(CH_TAB);
    send_char(CH_CR);
    send_char(CH_LF);
    send_text_end(" \"TW Fu\"");
    // form feed is not a leading blank: invalid, then drain
    send_char(CH_FF);
    send_text_end("xx");
    // end mark while waiting for a quote
    send_char(END_MARK);
    // quote inside a group, and the other quote inside a text
    send_text_end("\"AB\"");
    send_text_end("'TWFu\"'");
    // end mark inside a text
    send_text_end("\"AB");
    // characters after the closing quote are dropped
    send_text_end("\"TWFu\"zz");
    // top-bit characters inside a text
    send_text("\"A");
    send_char(8'hff);
    send_char(END_MARK);
    send_text("'");
    send_char(8'h80);
    send_char(END_MARK);
  endtask

  task automatic test_escapes();
    send_text_end("\"\\nTW\\u0046u\\t\"");
    send_text_end("\"\\f//\\/\\/\"");
    send_text_end("\"\\u004a\\u0041==\"");
    send_text_end("\"TQ\\u003d\\u0020=\"");
    send_text_end("\"\\x\"");
    send_text_end("\"\\u01\"");
    send_text_end("\"\\u00G0\"");
    send_text_end("\"\\u004G\"");
    // an escaped quote does not end the text as done: it is an invalid symbol
    send_text_end("\"\\u0022\"");
  endtask

  task automatic test_padding();
    send_text_end("\"=AAA\"");
    send_text_end("\"A=AA\"");
    send_text_end("\"AA=A\"");
    send_text_end("\"AA==A\"");
    send_text_end("\"AA== \"");
    send_text_end("\"AAA==\"");
  endtask

  task automatic test_capacity();
    write_capacity(16'd0);
    send_text_end("\"TWFu\"");
    write_capacity(16'd2);
    send_text_end("\"TWFu\"");
    write_capacity(16'd1);
    send_text_end("\"TQ==\"");
    // raise the limit in the middle of a text
    write_capacity(16'd3);
    send_text("\"TWFu");
    write_capacity(16'd4);
    send_text_end("TWFu\"");
    write_capacity(16'hffff);
    send_text_end("\"TWFu\"");
  endtask

  // Receiver holds off while a long text streams in, so the input stalls
  task automatic test_backpressure();
    tx_gaps = 1'b0;
    rx_hold_req = 80;
    send_char(CH_DQ);
    repeat (12) send_text("TWFu");
    send_text_end("\"");
    tx_gaps = 1'b1;
    wait_idle();
  endtask

  task automatic test_random();
    logic [7:0] txt [$];
    logic [7:0] quote, ch;
    logic [5:0] v;
    int groups, pads, target;
    target = chars_sent + RANDOM_CHARS;
    while (chars_sent < target) begin
      // occasional new limit, extremes included
      if ($urandom_range(0, 5) == 0) begin
        case ($urandom_range(0, 4))
          0:       write_capacity(16'd0);
          1:       write_capacity(16'($urandom_range(1, 8)));
          2:       write_capacity(16'($urandom_range(9, 300)));
          3:       write_capacity(16'hffff);
          default: write_capacity(16'($urandom));
        endcase
      end
      tx_gaps   = ($urandom_range(0, 3) != 0);
      rx_stalls = ($urandom_range(0, 3) != 0);
      txt = {};
      if ($urandom_range(0, 7) == 0) begin
        // raw noise
        repeat ($urandom_range(1, 6)) txt.push_back(8'($urandom_range(0, 255)));
        txt.push_back(END_MARK);
      end else begin
        repeat ($urandom_range(0, 2)) txt.push_back(pick_blank(1'b1));
        quote = $urandom_range(0, 1) ? CH_SQ : CH_DQ;
        txt.push_back(quote);
        groups = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 16) : $urandom_range(0, 4);
        pads = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 2) : 0;
        for (int g = 0; g < groups; g++) begin
          for (int k = 0; k < 4; k++) begin
            // blanks, raw or escaped
            if ($urandom_range(0, 7) == 0) begin
              case ($urandom_range(0, 3))
                0: txt.push_back(pick_blank(1'b0));
                1: begin txt.push_back(CH_BSL); txt.push_back("n"); end
                2: begin txt.push_back(CH_BSL); txt.push_back("t"); end
                default: begin txt.push_back(CH_BSL); txt.push_back("f"); end
              endcase
            end
            if (g == groups - 1 && k >= 4 - pads) begin
              ch = CH_EQ;
            end else begin
              v = 6'($urandom_range(0, 63));
              if (v < 26) ch = "A" + v;
              else if (v < 52) ch = "a" + (v - 26);
              else if (v < 62) ch = "0" + (v - 52);
              else ch = (v == 6'd62) ? CH_PLUS : CH_SLASH;
            end
            case ($urandom_range(0, 9))
              0: begin
                txt.push_back(CH_BSL);
                txt.push_back("u");
                txt.push_back("0");
                txt.push_back("0");
                txt.push_back(hex_char(ch[7:4], $urandom_range(0, 1)));
                txt.push_back(hex_char(ch[3:0], $urandom_range(0, 1)));
              end
              1: begin
                if (ch == CH_SLASH) txt.push_back(CH_BSL);
                txt.push_back(ch);
              end
              default: txt.push_back(ch);
            endcase
          end
        end
        txt.push_back(quote);
        if ($urandom_range(0, 4) == 0)
          repeat ($urandom_range(1, 3)) txt.push_back(8'($urandom_range(1, 255)));
        txt.push_back(END_MARK);
        // broken text: one character replaced
        if ($urandom_range(0, 4) == 0)
          txt[$urandom_range(0, txt.size() - 1)] = 8'($urandom_range(0, 255));
      end
      foreach (txt[i]) send_char(txt[i]);
    end
    tx_gaps   = 1'b1;
    rx_stalls = 1'b1;
  endtask

  // ---------------------------------------------------------------- receiver

  // Random stalls, plus long hold-offs on request, counted here
  initial begin : receiver
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left  = 0;
    out_ready  = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_req > 0) begin
        hold_left = rx_hold_req;
        rx_hold_req = 0;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
        if (rx_stalls) stall_left = pick_gap();
      end
    end
  end

  // ---------------------------------------------------------------- checking

  always @(posedge clk) begin : check_results
    b64jsd_pkg::res_t want;
    if (!rst && out_valid && out_ready) begin
      if (awaited_results.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result kind %0d data %02h count %0d last %0b",
                 $time, kind, data_byte, byte_count, last);
      end else begin
        want = awaited_results.pop_front();
        results_checked++;
        if (kind !== want.kind || data_byte !== want.data ||
            byte_count !== want.count || last !== want.last) begin
          mismatches++;
          $display("%0t: expected kind %0d data %02h count %0d last %0b,",
                   $time, want.kind, want.data, want.count, want.last,
                   " got kind %0d data %02h count %0d last %0b",
                   kind, data_byte, byte_count, last);
        end
      end
    end
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: run limit of %0d cycles reached", $time, CYCLE_LIMIT);
      $display("base64_json_string_decoder verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    rst       = 1'b1;
    cfg_write = 1'b0;
    capacity  = '0;
    in_valid  = 1'b0;
    text_char = '0;
    predictor_reset();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_plain_groups();
    test_framing();
    test_escapes();
    test_padding();
    test_capacity();
    test_backpressure();
    test_random();
    wait_idle();

    $display("Sent %0d characters in %0d texts (%0d decoded), checked %0d results.",
             chars_sent, texts_sent, chars_decoded, results_checked);
    $display("Capacity written %0d times; input stalled %0d cycles; %0d mismatches.",
             cap_writes, input_stall_cycles, mismatches);
    if (mismatches == 0) begin
      $display("base64_json_string_decoder verification clean");
    end else begin
      $display("base64_json_string_decoder verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/b64jsd_pkg.sv
design/base64_json_string_decoder.sv
verif/base64_json_string_decoder_tb.sv
